[hw/rtl/fehs_pkg.sv]
// Shared types, codes and the color palette of the fire heat spreader.
// No dependencies; used by the controller, the datapath and the top level.
package fehs_pkg;

  localparam logic [5:0] HEAT_MAX = 6'd36;

  localparam logic ACT_SPREAD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr;   // write one cell of the clearing pass
    logic load;  // capture an accepted item
    logic exec;  // finish the item: write back, fill the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing pass is on its last cell
    logic out_hold;  // output register is full and stalled
  } sts_t;

  // palette lookup, heat of 36 and above gives white (FFFFFF)
  function automatic logic [23:0] palette(input logic [5:0] h);
    logic [23:0] rgb;
    unique case (h)
      6'd0:    rgb = 24'h070707;
      6'd1:    rgb = 24'h1F0707;
      6'd2:    rgb = 24'h2F0F07;
      6'd3:    rgb = 24'h470F07;
      6'd4:    rgb = 24'h571707;
      6'd5:    rgb = 24'h671F07;
      6'd6:    rgb = 24'h771F07;
      6'd7:    rgb = 24'h8F2707;
      6'd8:    rgb = 24'h9F2F07;
      6'd9:    rgb = 24'hAF3F07;
      6'd10:   rgb = 24'hBF4707;
      6'd11:   rgb = 24'hC74707;
      6'd12:   rgb = 24'hDF4F07;
      6'd13:   rgb = 24'hDF5707;
      6'd14:   rgb = 24'hDF5707;
      6'd15:   rgb = 24'hD75F07;
      6'd16:   rgb = 24'hD75F07;
      6'd17:   rgb = 24'hD7670F;
      6'd18:   rgb = 24'hCF6F0F;
      6'd19:   rgb = 24'hCF770F;
      6'd20:   rgb = 24'hCF7F0F;
      6'd21:   rgb = 24'hCF8717;
      6'd22:   rgb = 24'hC78717;
      6'd23:   rgb = 24'hC78F17;
      6'd24:   rgb = 24'hC7971F;
      6'd25:   rgb = 24'hBF9F1F;
      6'd26:   rgb = 24'hBF9F1F;
      6'd27:   rgb = 24'hBFA727;
      6'd28:   rgb = 24'hBFA727;
      6'd29:   rgb = 24'hBFAF2F;
      6'd30:   rgb = 24'hB7AF2F;
      6'd31:   rgb = 24'hB7B72F;
      6'd32:   rgb = 24'hB7B737;
      6'd33:   rgb = 24'hCFCF6F;
      6'd34:   rgb = 24'hDFDF9F;
      6'd35:   rgb = 24'hEFEFC7;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

[hw/rtl/fehs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fehs_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 76800
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

[hw/rtl/fehs_ctrl.sv]
// Sequencer of the fire heat spreader: clearing pass, accept, fetch, execute.
// Depends on fehs_pkg for the state type and the command/status structs.
module fehs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fehs_pkg::sts_t sts,
  output fehs_pkg::cmd_t cmd
);

  fehs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fehs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      fehs_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = fehs_pkg::ST_IDLE;
        end
      end
      fehs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fehs_pkg::ST_FETCH;
        end
      end
      fehs_pkg::ST_FETCH: begin
        state_nxt = fehs_pkg::ST_EXEC;
      end
      fehs_pkg::ST_EXEC: begin
        // hold while the previous result still waits downstream
        if (!sts.out_hold) begin
          cmd.exec  = 1'b1;
          state_nxt = fehs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fehs_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

[hw/rtl/fehs_dp.sv]
// Datapath of the fire heat spreader: sweep position, heat store, spread
// arithmetic, palette lookup and output register. Uses fehs_pkg and fehs_ram.
module fehs_dp #(
  parameter int FB_WIDTH  = 320,
  parameter int FB_HEIGHT = 240
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fehs_pkg::cmd_t cmd,
  output fehs_pkg::sts_t sts,
  input  logic           in_action,
  input  logic [1:0]     in_rand_pick,
  input  logic [8:0]     in_pix_x,
  input  logic [7:0]     in_pix_y,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [5:0]     out_heat,
  output logic [16:0]    out_write_addr,
  output logic           out_write_dropped,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic           out_frame_done
);

  localparam int CELLS = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(FB_WIDTH);
  localparam int RW    = $clog2(FB_HEIGHT);
  localparam int BOT   = (FB_HEIGHT - 1) * FB_WIDTH;

  logic [AW-1:0] clr_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [AW-1:0] src_r;
  logic [AW-1:0] addr_r;
  logic          action_r;
  logic [1:0]    pick_r;

  logic [CW-1:0] px_sat;
  logic [RW-1:0] py_sat;
  logic [AW-1:0] pix_addr;

  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [5:0]    ram_wd;
  logic [5:0]    ram_rd;

  logic [AW-1:0] base;
  logic [AW:0]   base_inc;
  logic [AW-1:0] dst;
  logic          drop;
  logic [5:0]    spread_val;
  logic          last_row;
  logic          last_col;
  logic [23:0]   rgb;

  logic          out_valid_r;
  logic [5:0]    heat_r;
  logic [16:0]   waddr_r;
  logic          dropped_r;
  logic [23:0]   rgb_r;
  logic          done_r;

  // reads outside the frame saturate to the last column and row
  always_comb begin
    px_sat   = (32'(in_pix_x) >= FB_WIDTH)  ? CW'(FB_WIDTH - 1)  : CW'(in_pix_x);
    py_sat   = (32'(in_pix_y) >= FB_HEIGHT) ? RW'(FB_HEIGHT - 1) : RW'(in_pix_y);
    pix_addr = AW'(AW'(py_sat) * AW'(FB_WIDTH)) + AW'(px_sat);
  end

  // spread target: source minus one row; if heat > 0, plus one, minus pick
  always_comb begin
    base     = src_r - AW'(FB_WIDTH);
    base_inc = {1'b0, base} + (AW + 1)'(1);
    if (ram_rd == 6'd0) begin
      spread_val = 6'd0;
      dst        = base;
      drop       = 1'b0;
    end else begin
      spread_val = ram_rd - {5'd0, pick_r[0]};
      dst        = AW'(base_inc - (AW + 1)'(pick_r));
      drop       = base_inc < (AW + 1)'(pick_r);
    end
    last_row = row_r == RW'(FB_HEIGHT - 1);
    last_col = col_r == CW'(FB_WIDTH - 1);
    rgb      = fehs_pkg::palette(ram_rd);
  end

  always_comb begin
    if (cmd.clr) begin
      ram_we = 1'b1;
      ram_wa = clr_r;
      ram_wd = (clr_r >= AW'(BOT)) ? fehs_pkg::HEAT_MAX : 6'd0;
    end else begin
      ram_we = cmd.exec && (action_r == fehs_pkg::ACT_SPREAD) && !drop;
      ram_wa = dst;
      ram_wd = spread_val;
    end
  end

  fehs_ram #(
    .WIDTH(6),
    .DEPTH(CELLS)
  ) u_heat (
    .clk(clk),
    .we (ram_we),
    .wa (ram_wa),
    .wd (ram_wd),
    .ra (addr_r),
    .rd (ram_rd)
  );

  // clearing pass counter and sweep position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      col_r <= '0;
      row_r <= RW'(1);
      src_r <= AW'(FB_WIDTH);
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.exec && action_r == fehs_pkg::ACT_SPREAD) begin
        if (last_row) begin
          row_r <= RW'(1);
          if (last_col) begin
            col_r <= '0;
            src_r <= AW'(FB_WIDTH);
          end else begin
            col_r <= col_r + CW'(1);
            src_r <= AW'(col_r) + AW'(1) + AW'(FB_WIDTH);
          end
        end else begin
          row_r <= row_r + RW'(1);
          src_r <= src_r + AW'(FB_WIDTH);
        end
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      pick_r   <= in_rand_pick;
      addr_r   <= (in_action == fehs_pkg::ACT_READ) ? pix_addr : src_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (action_r == fehs_pkg::ACT_READ) begin
        heat_r    <= ram_rd;
        waddr_r   <= '0;
        dropped_r <= 1'b0;
        rgb_r     <= rgb;
        done_r    <= 1'b0;
      end else begin
        heat_r    <= spread_val;
        waddr_r   <= drop ? 17'd0 : 17'(dst);
        dropped_r <= drop;
        rgb_r     <= '0;
        done_r    <= last_row && last_col;
      end
    end
  end

  assign sts.clr_last = clr_r == AW'(CELLS - 1);
  assign sts.out_hold = out_valid_r && out_stall;

  assign out_valid         = out_valid_r;
  assign out_heat          = heat_r;
  assign out_write_addr    = waddr_r;
  assign out_write_dropped = dropped_r;
  assign out_red           = rgb_r[23:16];
  assign out_green         = rgb_r[15:8];
  assign out_blue          = rgb_r[7:0];
  assign out_frame_done    = done_r;

endmodule

[hw/rtl/fire_effect_heat_spread_core.sv]
// Fire heat spreader. An item passes the address, heat store read and output
// registers; the next item is accepted once the last has executed (capture,
// heat store read, execute), later while a result waits on out_stall. One RAM
// holds the heat. Reset (rst_n low, synchronous) starts a clearing pass over all
// FB_WIDTH*FB_HEIGHT cells (76800 at the defaults) that loads 0, bottom row 36;
// in_stall stays high until it ends. The sweep restarts at column 0, row 1.
module fire_effect_heat_spread_core #(
  parameter int FB_WIDTH  = 320,
  parameter int FB_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [1:0]  in_rand_pick,
  input  logic [8:0]  in_pix_x,
  input  logic [7:0]  in_pix_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_heat,
  output logic [16:0] out_write_addr,
  output logic        out_write_dropped,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_done
);

  fehs_pkg::cmd_t cmd;
  fehs_pkg::sts_t sts;

  fehs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  fehs_dp #(
    .FB_WIDTH (FB_WIDTH),
    .FB_HEIGHT(FB_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_rand_pick     (in_rand_pick),
    .in_pix_x         (in_pix_x),
    .in_pix_y         (in_pix_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_heat         (out_heat),
    .out_write_addr   (out_write_addr),
    .out_write_dropped(out_write_dropped),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_frame_done   (out_frame_done)
  );

endmodule
